// ----- design/sdsel_pkg.sv -----
// Shared constants and pipeline item type for the dispatch select unit.
`timescale 1ns / 1ps

package sdsel_pkg;

  localparam int SLOTS    = 4;
  localparam int SCHEDS   = 4;
  localparam int SCHED_W  = 2;
  localparam int CNT_W    = 3;
  localparam int TYPE_W   = 4;
  localparam int TYPE_CNT = 16;
  localparam int FREE_W   = 4;
  localparam int ENQ_W    = 3;
  localparam int PORT_W   = 3;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ALL_OR_NOTHING = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_COUNT    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT_MAP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENQ_WIDTHS     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALU_TYPE       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CSR_TYPE       = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FENCE_SUBOP    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MRET_SUBOP     = 4'd7;

  // One packet as it travels down the slot walk.
  typedef struct packed {
    logic                               pv;
    logic                               idle;
    logic [CNT_W-1:0]                   nslots;
    logic [CNT_W-1:0]                   rob;
    logic [CNT_W-1:0]                   lsq;
    logic [SLOTS-1:0]                   live;
    logic [SLOTS-1:0]                   exc;
    logic [SLOTS-1:0]                   nop;
    logic [SLOTS-1:0]                   direct;
    logic [SLOTS-1:0]                   cf;
    logic [SLOTS-1:0][SCHEDS-1:0]       cand;
    logic [SCHEDS-1:0][PORT_W-1:0]      ports;
    logic [CNT_W-1:0]                   walk;
    logic                               stop;
    logic [SLOTS-1:0][SCHED_W-1:0]      chosen;
  } walk_item_t;

endpackage

// ----- design/superscalar_dispatch_select_unit.sv -----
// Dispatch select unit: decode, per-slot scheduler walk and result register.
`timescale 1ns / 1ps

// Takes one packet beat per clock unless a held output backs up to in_tready, and returns
// one result beat per packet, in order. A beat passes a decode stage, one stage per slot
// (slot k claims a scheduler port against the port counts left by slots before it) and
// the result register. Throughput is one packet per cycle while the output is not held,
// set by the slot walk pipeline; a held output only stalls stages that are full, so
// bubbles still fill. Configuration writes are taken at any time but must only be made
// while the unit is empty.
module superscalar_dispatch_select_unit
  import sdsel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // packet_valid, reorder_idle, slot_count, exception_mask, type_codes, subop_codes,
  // dest_zero_mask, control_flow_mask, scheduler_busy_mask,
  // scheduler_free_entries, rob_grant_count, lsq_grant_count (low bit up)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // stall_res, ack_valid, taken_count, direct_commit_mask, target_schedulers
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STAGES = SLOTS + 1;

  // configuration
  logic                        aon_r;
  logic [CNT_W-1:0]            sched_cnt_r;
  logic [SCHEDS*TYPE_CNT-1:0]  support_r;
  logic [SCHEDS*ENQ_W-1:0]     enq_w_r;
  logic [TYPE_W-1:0]           alu_type_r;
  logic [TYPE_W-1:0]           csr_type_r;
  logic [TYPE_W-1:0]           fence_r;
  logic [TYPE_W-1:0]           mret_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aon_r       <= 1'b1;
      sched_cnt_r <= CNT_W'(4);
      support_r   <= '0;
      enq_w_r     <= '0;
      alu_type_r  <= '0;
      csr_type_r  <= '0;
      fence_r     <= '0;
      mret_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALL_OR_NOTHING: aon_r       <= cfg_data[0];
        CFG_SCHED_COUNT:    sched_cnt_r <= cfg_data[CNT_W-1:0];
        CFG_SUPPORT_MAP:    support_r   <= cfg_data[SCHEDS*TYPE_CNT-1:0];
        CFG_ENQ_WIDTHS:     enq_w_r     <= cfg_data[SCHEDS*ENQ_W-1:0];
        CFG_ALU_TYPE:       alu_type_r  <= cfg_data[TYPE_W-1:0];
        CFG_CSR_TYPE:       csr_type_r  <= cfg_data[TYPE_W-1:0];
        CFG_FENCE_SUBOP:    fence_r     <= cfg_data[TYPE_W-1:0];
        CFG_MRET_SUBOP:     mret_r      <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat fields
  logic                        f_pv;
  logic                        f_idle;
  logic [CNT_W-1:0]            f_slot_cnt;
  logic [SLOTS-1:0]            f_exc;
  logic [SLOTS*TYPE_W-1:0]     f_types;
  logic [SLOTS*TYPE_W-1:0]     f_subops;
  logic [SLOTS-1:0]            f_rdz;
  logic [SLOTS-1:0]            f_cf;
  logic [SCHEDS-1:0]           f_busy;
  logic [SCHEDS*FREE_W-1:0]    f_free;
  logic [CNT_W-1:0]            f_rob;
  logic [CNT_W-1:0]            f_lsq;

  assign f_pv       = in_tdata[0];
  assign f_idle     = in_tdata[1];
  assign f_slot_cnt = in_tdata[4:2];
  assign f_exc      = in_tdata[8:5];
  assign f_types    = in_tdata[24:9];
  assign f_subops   = in_tdata[40:25];
  assign f_rdz      = in_tdata[44:41];
  assign f_cf       = in_tdata[48:45];
  assign f_busy     = in_tdata[52:49];
  assign f_free     = in_tdata[68:53];
  assign f_rob      = in_tdata[71:69];
  assign f_lsq      = in_tdata[74:72];

  // pipeline
  walk_item_t        stg_r   [0:STAGES-1];
  walk_item_t        stg_nxt [0:STAGES-1];
  logic [STAGES-1:0] stg_vld_r;
  logic [STAGES:0]   en;
  logic              out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  // a stage loads when it is empty or its content moves on
  assign en[STAGES] = !out_vld_r || out_tready;
  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_en
      assign en[g] = !stg_vld_r[g] || en[g+1];
    end
  endgenerate
  assign in_tready = en[0];

  // decode
  logic [CNT_W-1:0] nsched;
  walk_item_t       dec;

  assign nsched = (sched_cnt_r > CNT_W'(SCHEDS)) ? CNT_W'(SCHEDS) : sched_cnt_r;

  always_comb begin
    dec        = '0;
    dec.pv     = f_pv;
    dec.idle   = f_idle;
    dec.nslots = (f_slot_cnt > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : f_slot_cnt;
    dec.rob    = f_rob;
    dec.lsq    = f_lsq;
    for (int i = 0; i < SLOTS; i++) begin
      dec.live[i]   = CNT_W'(i) < dec.nslots;
      dec.exc[i]    = f_exc[i];
      dec.cf[i]     = f_cf[i];
      dec.nop[i]    = (f_types[i*TYPE_W +: TYPE_W] == alu_type_r) && f_rdz[i];
      dec.direct[i] = f_exc[i] || dec.nop[i] ||
                      ((f_types[i*TYPE_W +: TYPE_W] == csr_type_r) &&
                       ((f_subops[i*TYPE_W +: TYPE_W] == fence_r) ||
                        (f_subops[i*TYPE_W +: TYPE_W] == mret_r)));
      for (int s = 0; s < SCHEDS; s++) begin
        dec.cand[i][s] = support_r[s*TYPE_CNT + int'(f_types[i*TYPE_W +: TYPE_W])] &&
                         !f_busy[s] && (CNT_W'(s) < nsched);
      end
    end
    for (int s = 0; s < SCHEDS; s++) begin
      if (f_free[s*FREE_W +: FREE_W] < {1'b0, enq_w_r[s*ENQ_W +: ENQ_W]}) begin
        dec.ports[s] = f_free[s*FREE_W +: PORT_W];
      end else begin
        dec.ports[s] = enq_w_r[s*ENQ_W +: ENQ_W];
      end
    end
  end

  assign stg_nxt[0] = dec;

  // one stage per slot of the walk
  generate
    for (g = 0; g < SLOTS; g++) begin : g_slot
      walk_item_t          cur;
      walk_item_t          nxt;
      logic [SCHEDS-1:0]   avail;
      logic                found;
      logic [SCHED_W-1:0]  sel;

      assign cur = stg_r[g];

      always_comb begin
        for (int s = 0; s < SCHEDS; s++) begin
          avail[s] = cur.cand[g][s] && (cur.ports[s] != '0);
        end
        found = 1'b0;
        sel   = '0;
        for (int s = SCHEDS - 1; s >= 0; s--) begin
          if (avail[s]) begin
            found = 1'b1;
            sel   = SCHED_W'(s);
          end
        end
        nxt = cur;
        if (!cur.stop && cur.live[g]) begin
          priority if (cur.exc[g]) begin
            nxt.walk = cur.walk + CNT_W'(1);
            nxt.stop = 1'b1;
          end else if (cur.nop[g]) begin
            nxt.walk = cur.walk + CNT_W'(1);
          end else if (!found) begin
            nxt.stop = 1'b1;
          end else begin
            nxt.ports[sel] = cur.ports[sel] - PORT_W'(1);
            nxt.chosen[g]  = sel;
            nxt.walk       = cur.walk + CNT_W'(1);
            if (!aon_r && cur.cf[g]) begin
              nxt.stop = 1'b1;
            end
          end
        end
      end

      assign stg_nxt[g+1] = nxt;
    end
  endgenerate

  generate
    for (g = 0; g < STAGES; g++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_vld_r[g] <= 1'b0;
        end else if (en[g]) begin
          stg_vld_r[g] <= (g == 0) ? in_tvalid : stg_vld_r[(g == 0) ? 0 : g - 1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[g]) begin
          stg_r[g] <= stg_nxt[g];
        end
      end
    end
  endgenerate

  // grant limits and the result
  walk_item_t                  fin;
  logic [CNT_W-1:0]            taken;
  logic [CNT_W-1:0]            taken_lim;
  logic                        res_stall;
  logic                        res_ack;
  logic [CNT_W-1:0]            res_taken;
  logic [SLOTS-1:0]            res_commit;
  logic [SLOTS*SCHED_W-1:0]    res_targets;

  assign fin       = stg_r[STAGES-1];
  assign taken_lim = (fin.rob < fin.walk) ? fin.rob : fin.walk;
  assign taken     = (fin.lsq < taken_lim) ? fin.lsq : taken_lim;

  always_comb begin
    res_stall   = 1'b0;
    res_ack     = 1'b0;
    res_taken   = '0;
    res_commit  = '0;
    res_targets = '0;
    priority if (!fin.pv) begin
      res_stall = 1'b0;
    end else if (!fin.idle) begin
      res_stall = 1'b1;
    end else if (aon_r && (taken < fin.nslots)) begin
      res_stall = 1'b1;
    end else begin
      res_ack   = 1'b1;
      res_taken = taken;
      for (int i = 0; i < SLOTS; i++) begin
        if (CNT_W'(i) < taken) begin
          if (fin.direct[i]) begin
            res_commit[i] = 1'b1;
          end else begin
            res_targets[i*SCHED_W +: SCHED_W] = fin.chosen[i];
          end
        end
      end
    end
  end

  assign out_data_nxt = {7'b0, res_targets, res_commit, res_taken, res_ack, res_stall};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en[STAGES]) begin
      out_vld_r <= stg_vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // checks on the result beat
  logic                     chk_stall;
  logic                     chk_ack;
  logic [CNT_W-1:0]         chk_taken;
  logic [SLOTS-1:0]         chk_commit;
  logic [SLOTS*SCHED_W-1:0] chk_targets;

  assign chk_stall   = out_data_r[0];
  assign chk_ack     = out_data_r[1];
  assign chk_taken   = out_data_r[4:2];
  assign chk_commit  = out_data_r[8:5];
  assign chk_targets = out_data_r[16:9];

  a_stall_ack_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(chk_stall && chk_ack))
    else $error("stall and acknowledge raised together");

  a_taken_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (chk_taken <= CNT_W'(SLOTS)))
    else $error("taken count beyond slot count");

  a_commit_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ((chk_commit >> chk_taken) == '0))
    else $error("direct commit flagged on an untaken slot");

  a_no_ack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !chk_ack) |-> (chk_taken == '0 && chk_commit == '0 && chk_targets == '0))
    else $error("payload present without acknowledge");

endmodule
